// ===== rtl/core/ghash_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghash_pkg
// Shared types and constants of the GHASH authenticator.
// ----------------------------------------------------------------------------
package ghash_pkg;

  localparam int unsigned DigitBitsDefault = 8;
  localparam int unsigned QueueDepthDefault = 2;
  localparam int unsigned CountWidth = 61;
  localparam logic [7:0] RedTop = 8'he1;

  typedef enum logic [1:0] {
    CmdRestart = 2'd0,
    CmdAad     = 2'd1,
    CmdText    = 2'd2,
    CmdFinish  = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    CfgKeyHigh = 1'b0,
    CfgKeyLow  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StOut
  } state_e;

  // Classified item handed from front to back.
  typedef struct packed {
    cmd_e         cmd;
    logic [127:0] blk;
    logic [4:0]   nbytes;
  } work_t;

endpackage

// ===== rtl/core/ghash_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghash_front
// Accepts items, masks trailing bytes of all but finish items, saturates the count, queues work.
// ----------------------------------------------------------------------------
module ghash_front #(
  parameter int unsigned QueueDepth = ghash_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       command_i,
  input  logic [63:0]      block_high_i,
  input  logic [63:0]      block_low_i,
  input  logic [4:0]       valid_bytes_i,
  output logic             wk_valid_o,
  input  logic             wk_ready_i,
  output ghash_pkg::work_t wk_o
);
  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  ghash_pkg::work_t mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  ghash_pkg::work_t item;
  logic [4:0]   n;
  logic [127:0] mask;
  logic push, pop;

  always_comb begin
    n = (valid_bytes_i > 5'd16) ? 5'd16 : valid_bytes_i;
    for (int b = 0; b < 16; b++) begin
      mask[127-8*b -: 8] = (5'(b) < n) ? 8'hff : 8'h00;
    end
    item.cmd = ghash_pkg::cmd_e'(command_i);
    item.nbytes = n;
    // keep full block on finish: it carries the tag mask
    if (item.cmd == ghash_pkg::CmdFinish) begin
      item.blk = {block_high_i, block_low_i};
    end else begin
      item.blk = {block_high_i, block_low_i} & mask;
    end
  end

  assign in_ready_o = (cnt_q != (PtrW+1)'(QueueDepth));
  assign push = in_valid_i && in_ready_o;
  assign wk_valid_o = (cnt_q != '0);
  assign pop = wk_valid_o && wk_ready_i;
  assign wk_o = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push) wr_d = (wr_q == PtrW'(QueueDepth-1)) ? '0 : wr_q + 1'b1;
    if (pop)  rd_d = (rd_q == PtrW'(QueueDepth-1)) ? '0 : rd_q + 1'b1;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item;
  end
endmodule

// ===== rtl/core/ghash_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghash_back
// Holds accumulator and byte counts; runs the digit-serial GF(2^128) multiply.
// ----------------------------------------------------------------------------
module ghash_back #(
  parameter int unsigned DigitBits = ghash_pkg::DigitBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [63:0]      cfg_data_i,
  input  logic             wk_valid_i,
  output logic             wk_ready_o,
  input  ghash_pkg::work_t wk_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [63:0]      result_high_o,
  output logic [63:0]      result_low_o,
  output logic             is_tag_o
);
  localparam int unsigned Steps = (128 + DigitBits - 1) / DigitBits;
  localparam int unsigned StepW = (Steps > 1) ? $clog2(Steps) : 1;
  localparam int unsigned CW = ghash_pkg::CountWidth;

  ghash_pkg::state_e st_q, st_d;
  logic [127:0] h_q, acc_q, acc_d, x_q, x_d, z_q, z_d, v_q, v_d, msk_q, msk_d;
  logic [CW-1:0] aad_q, aad_d, txt_q, txt_d;
  logic [StepW-1:0] step_q, step_d;
  logic tag_q, tag_d;
  logic [127:0] zn, vn, xn;

  // DigitBits bits of the multiplier per cycle
  always_comb begin
    zn = z_q;
    vn = v_q;
    xn = x_q;
    for (int k = 0; k < DigitBits; k++) begin
      if (xn[127]) zn = zn ^ vn;
      xn = {xn[126:0], 1'b0};
      vn = {1'b0, vn[127:1]} ^ (vn[0] ? {ghash_pkg::RedTop, 120'b0} : 128'b0);
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ghash_pkg::StIdle: begin
        if (wk_valid_i) begin
          if (wk_i.cmd == ghash_pkg::CmdRestart || wk_i.nbytes == 5'd0
              && wk_i.cmd != ghash_pkg::CmdFinish) st_d = ghash_pkg::StOut;
          else st_d = ghash_pkg::StMul;
        end
      end
      ghash_pkg::StMul: if (step_q == StepW'(Steps-1)) st_d = ghash_pkg::StOut;
      ghash_pkg::StOut: if (out_ready_i) st_d = ghash_pkg::StIdle;
      default: st_d = ghash_pkg::StIdle;
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    aad_d = aad_q;
    txt_d = txt_q;
    x_d = x_q;
    z_d = z_q;
    v_d = v_q;
    msk_d = msk_q;
    tag_d = tag_q;
    step_d = step_q;
    case (st_q)
      ghash_pkg::StIdle: begin
        step_d = '0;
        z_d = '0;
        v_d = h_q;
        msk_d = '0;
        tag_d = 1'b0;
        if (wk_valid_i) begin
          case (wk_i.cmd)
            ghash_pkg::CmdRestart: begin
              acc_d = '0;
              aad_d = '0;
              txt_d = '0;
            end
            ghash_pkg::CmdFinish: begin
              x_d = acc_q ^ {aad_q, 3'b0, txt_q, 3'b0};
              msk_d = wk_i.blk;
              tag_d = 1'b1;
            end
            default: begin
              x_d = acc_q ^ wk_i.blk;
              if (wk_i.nbytes != 5'd0) begin
                if (wk_i.cmd == ghash_pkg::CmdAad) aad_d = aad_q + CW'(wk_i.nbytes);
                else txt_d = txt_q + CW'(wk_i.nbytes);
              end
            end
          endcase
        end
      end
      ghash_pkg::StMul: begin
        z_d = zn;
        v_d = vn;
        x_d = xn;
        step_d = step_q + 1'b1;
        if (step_q == StepW'(Steps-1)) acc_d = zn;
      end
      default: ;
    endcase
  end

  assign wk_ready_o = (st_q == ghash_pkg::StIdle);
  assign out_valid_o = (st_q == ghash_pkg::StOut);
  assign result_high_o = acc_q[127:64] ^ msk_q[127:64];
  assign result_low_o = acc_q[63:0] ^ msk_q[63:0];
  assign is_tag_o = tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ghash_pkg::StIdle;
      h_q <= '0;
      acc_q <= '0;
      aad_q <= '0;
      txt_q <= '0;
      step_q <= '0;
      tag_q <= 1'b0;
      msk_q <= '0;
    end else begin
      st_q <= st_d;
      acc_q <= acc_d;
      aad_q <= aad_d;
      txt_q <= txt_d;
      step_q <= step_d;
      tag_q <= tag_d;
      msk_q <= msk_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == ghash_pkg::CfgKeyHigh) h_q[127:64] <= cfg_data_i;
        else h_q[63:0] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    z_q <= z_d;
    v_q <= v_d;
  end
endmodule

// ===== rtl/core/ghash_authenticator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghash_authenticator
// GCM GHASH engine with decoupled intake queue and multiply back end.
// ----------------------------------------------------------------------------
// Each absorb or finish item passes through the back end's digit-serial
// GF(2^128) multiplier, which handles DIGIT_BITS multiplier bits per cycle,
// and then waits in the output state; restart and zero-byte absorbs skip the
// multiply. A two-entry queue takes items while the multiplier runs. Write
// the hash key only while idle.
module ghash_authenticator #(
  parameter int unsigned DIGIT_BITS = ghash_pkg::DigitBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  input  logic [4:0]  valid_bytes_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o,
  output logic        is_tag_o
);
  ghash_pkg::work_t wk;
  logic wk_valid, wk_ready;

  ghash_front #(.QueueDepth(ghash_pkg::QueueDepthDefault)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .block_high_i,
    .block_low_i, .valid_bytes_i,
    .wk_valid_o(wk_valid), .wk_ready_i(wk_ready), .wk_o(wk)
  );

  ghash_back #(.DigitBits(DIGIT_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .wk_valid_i(wk_valid), .wk_ready_o(wk_ready), .wk_i(wk),
    .out_valid_o, .out_ready_i, .result_high_o, .result_low_o, .is_tag_o
  );

  // hold result while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_high_o)
    && $stable(result_low_o)) else $error("result changed while stalled");

  // take no work while a result waits
  a_no_work_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !wk_ready) else $error("back end took work with result pending");
endmodule
